// ----- sv/fra_pkg.sv -----
package fra_pkg;
  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int AW = 32;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_REG   = 2'd0;
  localparam mode_t MODE_ALLOC = 2'd1;
  localparam mode_t MODE_QUERY = 2'd2;
  localparam mode_t MODE_MAX   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_PASS1, S_PASS2, S_WRITE, S_DONE
  } state_t;

  // one table entry as it travels along the cell chain
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
  } entry_t;
endpackage

// ----- sv/fra_cell.sv -----
// One storage cell: holds an entry and passes it to its neighbor when shifting.
module fra_cell import fra_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  entry_t din,
  output entry_t dout
);
  entry_t e_r;
  always_ff @(posedge clk) begin
    if (shift) e_r <= din;
  end
  assign dout = e_r;
endmodule

// ----- sv/fra_chain.sv -----
// Ring of cells; each shift rotates the table one slot. Head is cell 0.
module fra_chain import fra_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  logic   replace,
  input  entry_t new_entry,
  output entry_t head
);
  entry_t link [ENTRIES];
  entry_t feed;
  // head re-enters at the tail, optionally updated
  assign feed = replace ? new_entry : link[0];
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == ENTRIES - 1) begin : g_tail
        fra_cell u_cell (.clk(clk), .shift(shift), .din(feed), .dout(link[g]));
      end else begin : g_mid
        fra_cell u_cell (.clk(clk), .shift(shift), .din(link[g+1]), .dout(link[g]));
      end
    end
  endgenerate
  assign head = link[0];
endmodule

// ----- sv/free_region_allocator.sv -----
// Free-region allocator. Pulse start while busy is low; the result word appears
// on out_* for one cycle with out_valid and cannot be stalled. The table is a
// ring of 64 cells read one entry per cycle at its head. A query, an allocate
// that finds an aligned entry and a register that lands in an existing entry
// need one pass over the table. A register that appends, an allocate that
// falls back to a padded fit and every allocate-largest (one pass finds the
// maximum, one takes it) need two passes. busy drops in the cycle after the
// result, when the next word can be accepted.
module free_region_allocator import fra_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      in_mode,
  input  logic [31:0]     in_position,
  input  logic [31:0]     in_length,
  input  logic [4:0]      in_align_log2,
  output logic            out_valid,
  output logic [31:0]     out_address,
  output logic [31:0]     out_granted_length,
  output logic [1:0]      out_status,
  output logic            out_covered
);
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W:0]   step_r;
  mode_t            mode_r;
  logic [AW-1:0]    pos_r, len_r, amask_r, best_r;
  logic [AW:0]      size_r;
  logic             hit_r, cov_r;
  logic [AW-1:0]    haddr_r;

  entry_t head, new_entry;
  logic   shift, replace;

  fra_chain u_chain (.clk(clk), .shift(shift), .replace(replace),
    .new_entry(new_entry), .head(head));

  // per-entry evaluation at the head
  logic          live, last;
  logic [AW:0]   h_end, r_end;
  logic          contains, overlaps, fit1, fit2;
  logic [AW-1:0] pad, nstart, nend;
  assign live  = {1'b0, step_r} < {1'b0, count_r};
  assign last  = step_r == (IDX_W+1)'(ENTRIES - 1);
  assign h_end = {1'b0, head.start} + {1'b0, head.len};
  assign r_end = {1'b0, pos_r} + {1'b0, len_r};
  assign contains = head.start <= pos_r && r_end <= h_end;
  assign overlaps = {1'b0, head.start} < r_end && {1'b0, pos_r} < h_end;
  assign nstart = (head.start < pos_r) ? head.start : pos_r;
  assign nend   = (h_end > r_end) ? h_end[AW-1:0] : r_end[AW-1:0];
  assign pad  = (AW'(0) - head.start) & amask_r;
  assign fit1 = {1'b0, head.len} >= size_r && (head.start & amask_r) == '0;
  assign fit2 = {1'b0, head.len} >= size_r && (head.len - size_r[AW-1:0]) >= pad;

  // take action only on the first live hit within a pass
  logic act;
  always_comb begin
    act = 1'b0;
    if (live && !hit_r) begin
      case (state_r)
        S_PASS1: begin
          case (mode_r)
            MODE_REG:   act = contains || overlaps;
            MODE_QUERY: act = pos_r >= head.start && (pos_r - head.start) < head.len;
            MODE_ALLOC: act = fit1;
            default:    act = 1'b0;
          endcase
        end
        S_PASS2: act = fit2;
        default: act = 1'b0;
      endcase
    end
  end

  // entry update for the acting entry
  always_comb begin
    new_entry = head;
    replace = 1'b0;
    if (act && mode_r == MODE_REG) begin
      replace = !contains;
      new_entry.start = nstart;
      new_entry.len = nend - nstart;
    end else if (act && state_r == S_PASS1 && mode_r != MODE_QUERY) begin
      replace = 1'b1;
      new_entry.start = head.start + size_r[AW-1:0];
      new_entry.len = head.len - size_r[AW-1:0];
    end else if (act && state_r == S_PASS2) begin
      replace = 1'b1;
      new_entry.start = head.start + size_r[AW-1:0] + pad;
      new_entry.len = head.len - size_r[AW-1:0] - pad;
    end
    // append slot: entry at index count during the write state, written once
    if (state_r == S_WRITE) begin
      replace = !hit_r && step_r == {1'b0, count_r[IDX_W-1:0]} && !count_r[IDX_W];
      new_entry.start = pos_r;
      new_entry.len = len_r;
    end
  end

  assign shift = state_r == S_PASS1 || state_r == S_PASS2 || state_r == S_WRITE;

  // next state
  logic need_write;
  assign need_write = mode_r == MODE_REG && !hit_r && !count_r[IDX_W];
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_PASS1;
      S_PASS1: if (last) begin
        if ((mode_r == MODE_ALLOC && !(hit_r || act)) || mode_r == MODE_MAX)
          state_nxt = S_PASS2;
        else if (mode_r == MODE_REG && !(hit_r || act) && !count_r[IDX_W])
          state_nxt = S_WRITE;
        else state_nxt = S_DONE;
      end
      S_PASS2: if (last) state_nxt = S_DONE;
      S_WRITE: if (last) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WRITE && replace) count_r <= count_r + CNT_W'(1);
    end
  end

  // datapath registers
  logic [AW:0] room_len;
  logic [AW-1:0] amask_in;
  assign amask_in = (AW'(1) << in_align_log2) - AW'(1);
  assign room_len = {1'b0, in_length};
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        mode_r  <= in_mode;
        pos_r   <= in_position;
        amask_r <= (in_mode == MODE_MAX) ? '0 : amask_in;
        len_r   <= (room_len > {1'b0, ~in_position}) ? ~in_position : in_length;
        size_r  <= ({1'b0, in_length} + {1'b0, amask_in}) & ~{1'b0, amask_in};
        step_r  <= '0;
        hit_r   <= 1'b0;
        cov_r   <= 1'b0;
        best_r  <= '0;
        haddr_r <= '0;
      end
      S_PREP: begin
        step_r <= '0;
      end
      default: begin
        step_r <= (last) ? '0 : step_r + (IDX_W+1)'(1);
        if (act) begin
          hit_r <= 1'b1;
          cov_r <= mode_r == MODE_QUERY;
          haddr_r <= (state_r == S_PASS2) ? head.start + pad : head.start;
        end
        // the append marks the word as served
        if (state_r == S_WRITE && replace) hit_r <= 1'b1;
        if (state_r == S_PASS1 && last && mode_r == MODE_ALLOC && !(hit_r || act))
          hit_r <= 1'b0;
        // allocate-largest: pass 1 finds the maximum, pass 2 takes it
        if (mode_r == MODE_MAX && state_r == S_PASS1) begin
          if (live && head.len > best_r) best_r <= head.len;
          if (last) size_r <= {1'b0, (live && head.len > best_r) ? head.len : best_r};
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    busy = state_r != S_IDLE;
    out_valid = state_r == S_DONE;
    out_address = '0;
    out_granted_length = '0;
    out_covered = 1'b0;
    out_status = ST_DONE;
    case (mode_r)
      MODE_REG:   if (!hit_r && count_r[IDX_W] && state_r == S_DONE &&
                      !need_write) out_status = ST_FULL;
      MODE_QUERY: out_covered = cov_r;
      default: begin
        if (hit_r && count_r != '0) begin
          out_address = haddr_r;
          out_granted_length = size_r[AW-1:0];
        end else out_status = ST_NOFIT;
      end
    endcase
  end
endmodule

// ----- sv/fra_checker.sv -----
module fra_checker import fra_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [1:0] out_status,
  input logic out_covered,
  input logic [31:0] out_address
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_address == '0 && !out_covered)
    else $error("failed result carries data");
endmodule

bind free_region_allocator fra_checker u_fra_checker (.clk(clk), .rst_n(rst_n),
  .start(start), .busy(busy), .out_valid(out_valid), .out_status(out_status),
  .out_covered(out_covered), .out_address(out_address));
